[design/hds_pkg.sv]
package hds_pkg;

   // Field widths fixed by the stream format
   localparam int VAL_W     = 18;   // signed Q2.16 temperature
   localparam int FRAC_W    = 16;   // fraction bits of values and ratios
   localparam int IDX_W     = 8;    // row / column index on the result channel
   localparam int COEF_W    = 15;   // unsigned Q0.16 ratio, below one half
   localparam int SIZE_W    = 9;    // grid size register
   localparam int SUM_W     = VAL_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = COEF_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   // What travels with a cell through the arithmetic pipeline
   typedef struct packed {
      logic             up;        // a result for the row above is due
      logic             interior;  // row above is an interior cell here
      logic             last_row;  // cell is on the last row: echo it too
      logic             last;      // echoed cell closes the grid
      logic [IDX_W-1:0] up_row;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   typedef struct packed {
      val_type          value;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } rsp_type;

endpackage

[design/heat_diffusion_stencil_step_top.sv]
// One explicit time step of 2D heat diffusion on a grid streamed in raster order.
// Request channel (req_): one beat per grid cell, old temperature in signed Q2.16;
//   req_frame_start puts the beat at row 0, column 0.
// Response channel (rsp_): the beat for cell (r,c) yields the new value of cell
//   (r-1,c); row 0 yields nothing, and each last-row beat also echoes itself, so
//   those beats yield two results, row above first. Border cells pass unchanged.
// Config channel (csr_): coef_x, coef_y, grid_rows, grid_cols by index; always
//   ready. Write only while no beat is in flight.
// Path: an accepted beat passes the read, operand and product stages into the
//   output queue, whose registered count raises rsp_valid.
// Throughput: one beat per cycle while the queue has room; last-row beats yield
//   two results, bound by the single response port. Both line stores are read at
//   accept, written back from the read stage; racing reads get the last write-back.
// Reset: position returns to row 0, column 0, ratios clear, size returns to
//   256 x 256. Line stores are not cleared; row 0 fills them before use.
// Stall: a four-beat output queue parts the sides; when fewer than two slots are
//   free the whole pipeline holds and req_ready drops.
module heat_diffusion_stencil_step_top
   import hds_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [VAL_W-1:0]     req_cell_value,
   input  logic                 req_frame_start,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VAL_W-1:0]     rsp_new_value,
   output logic [IDX_W-1:0]     rsp_row_index,
   output logic [IDX_W-1:0]     rsp_col_index,
   output logic                 rsp_frame_last,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_COLS);
   localparam int RCW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
   localparam int CCW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   // Configuration registers
   logic [COEF_W-1:0] coef_x_ff, coef_y_ff;
   logic [SIZE_W-1:0] grid_rows_ff, grid_cols_ff;
   logic              csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_ff    <= '0;
         coef_y_ff    <= '0;
         grid_rows_ff <= SIZE_RESET;
         grid_cols_ff <= SIZE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COEF_X:    coef_x_ff    <= csr_data[COEF_W-1:0];
            CSR_COEF_Y:    coef_y_ff    <= csr_data[COEF_W-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_data[SIZE_W-1:0];
            CSR_GRID_COLS: grid_cols_ff <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the grid size into the range the line stores support
   logic [RCW-1:0] rows_ext, rows_clamp;
   logic [CCW-1:0] cols_ext, cols_clamp;
   logic [RW:0]    rows;
   logic [CW:0]    cols;

   always_comb begin
      rows_ext = RCW'(grid_rows_ff);
      cols_ext = CCW'(grid_cols_ff);
      if (rows_ext < RCW'(3)) begin
         rows_clamp = RCW'(3);
      end else if (rows_ext > RCW'(MAX_ROWS)) begin
         rows_clamp = RCW'(MAX_ROWS);
      end else begin
         rows_clamp = rows_ext;
      end
      if (cols_ext < CCW'(3)) begin
         cols_clamp = CCW'(3);
      end else if (cols_ext > CCW'(MAX_COLS)) begin
         cols_clamp = CCW'(MAX_COLS);
      end else begin
         cols_clamp = cols_ext;
      end
      rows = rows_clamp[RW:0];
      cols = cols_clamp[CW:0];
   end

   // Pipeline: position and line-store read, operand pairing, products, queue
   logic    adv;
   logic    accept;
   logic    op_valid;
   tag_type op_tag;
   val_type op_centre, op_south;
   sum_type op_ns, op_we;
   logic    push0, push1;
   rsp_type rsp0, rsp1, rsp_head;

   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   hds_line #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_line (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .accept      (accept),
      .cell_value  (req_cell_value),
      .frame_start (req_frame_start),
      .rows        (rows),
      .cols        (cols),
      .out_valid   (op_valid),
      .out_tag     (op_tag),
      .out_centre  (op_centre),
      .out_south   (op_south),
      .out_ns      (op_ns),
      .out_we      (op_we)
   );

   hds_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .coef_x    (coef_x_ff),
      .coef_y    (coef_y_ff),
      .in_valid  (op_valid),
      .in_tag    (op_tag),
      .in_centre (op_centre),
      .in_south  (op_south),
      .in_ns     (op_ns),
      .in_we     (op_we),
      .push0     (push0),
      .push1     (push1),
      .rsp0      (rsp0),
      .rsp1      (rsp1)
   );

   hds_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .rsp0      (rsp0),
      .rsp1      (rsp1),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_head)
   );

   // Drive the response beat from the queue head
   assign rsp_new_value  = rsp_head.value;
   assign rsp_row_index  = rsp_head.row;
   assign rsp_col_index  = rsp_head.col;
   assign rsp_frame_last = rsp_head.last;

endmodule

[design/hds_ram.sv]
module hds_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[design/hds_line.sv]
module hds_line
   import hds_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256,
   localparam int RW = $clog2(MAX_ROWS),
   localparam int CW = $clog2(MAX_COLS)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        accept,
   input  val_type     cell_value,
   input  logic        frame_start,
   input  logic [RW:0] rows,
   input  logic [CW:0] cols,
   output logic        out_valid,
   output tag_type     out_tag,
   output val_type     out_centre,
   output val_type     out_south,
   output sum_type     out_ns,
   output sum_type     out_we
);

   // Raster position of the next cell
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   logic [RW:0]   r_start, r_step, r_wrap, r_nx;
   logic [CW:0]   c_start, c_nx;
   logic          c_over;
   logic [RW-1:0] r, r_up;
   logic [CW-1:0] c, c_east, c_west;
   logic          col_end, row_end;
   tag_type       tag_in;

   always_comb begin
      r_start = frame_start ? '0 : {1'b0, row_ff};
      c_start = frame_start ? '0 : {1'b0, col_ff};
      c_over  = c_start >= cols;
      r_step  = c_over ? r_start + 1'b1 : r_start;
      r_wrap  = (r_step >= rows) ? '0 : r_step;
      r       = r_wrap[RW-1:0];
      c       = c_over ? '0 : c_start[CW-1:0];
      r_up    = r - 1'b1;
      c_east  = c + 1'b1;
      c_west  = c - 1'b1;

      c_nx    = {1'b0, c} + 1'b1;
      r_nx    = {1'b0, r} + 1'b1;
      col_end = c_nx >= cols;
      row_end = r_nx >= rows;

      col_in  = col_end ? '0 : c_nx[CW-1:0];
      row_in  = col_end ? (row_end ? '0 : r_nx[RW-1:0]) : r;

      tag_in.up       = r != '0;
      tag_in.interior = (r_up != '0) && (r != '0) && (c != '0) && !col_end;
      tag_in.last_row = row_end;
      tag_in.last     = row_end && col_end;
      tag_in.up_row   = IDX_W'(r_up);
      tag_in.row      = IDX_W'(r);
      tag_in.col      = IDX_W'(c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Read stage: the line stores answer in the cycle after accept
   logic          b_valid_ff;
   tag_type       b_tag_ff;
   val_type       b_v_ff;
   logic [CW-1:0] b_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_tag_ff <= tag_in;
         b_v_ff   <= cell_value;
         b_col_ff <= c;
      end
   end

   // Last write-back, held for forwarding into a read that raced it
   logic          wr_valid_ff;
   logic [CW-1:0] wr_addr_ff;
   val_type       wr_prev_ff;
   val_type       wr_older_ff;

   logic          b_fire;
   logic [CW-1:0] b_east, b_west;
   logic          hit_c, hit_e, hit_w;
   val_type       prev_a, prev_b, older_a, older_b;
   val_type       centre, north, east, west;

   assign b_fire = b_valid_ff && adv;

   hds_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_prev_ram (
      .clock     (clock),
      .wr_en     (b_fire),
      .wr_addr   (b_col_ff),
      .wr_data   (b_v_ff),
      .rd_en     (accept),
      .rd_addr_a (c),
      .rd_addr_b (c_east),
      .rd_data_a (prev_a),
      .rd_data_b (prev_b)
   );

   hds_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_older_ram (
      .clock     (clock),
      .wr_en     (b_fire),
      .wr_addr   (b_col_ff),
      .wr_data   (centre),
      .rd_en     (accept),
      .rd_addr_a (c),
      .rd_addr_b (c_west),
      .rd_data_a (older_a),
      .rd_data_b (older_b)
   );

   always_comb begin
      b_east = b_col_ff + 1'b1;
      b_west = b_col_ff - 1'b1;
      hit_c  = wr_valid_ff && (wr_addr_ff == b_col_ff);
      hit_e  = wr_valid_ff && (wr_addr_ff == b_east);
      hit_w  = wr_valid_ff && (wr_addr_ff == b_west);
      centre = hit_c ? wr_prev_ff  : prev_a;
      north  = hit_c ? wr_older_ff : older_a;
      east   = hit_e ? wr_prev_ff  : prev_b;
      west   = hit_w ? wr_older_ff : older_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (b_fire) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         wr_addr_ff  <= b_col_ff;
         wr_prev_ff  <= b_v_ff;
         wr_older_ff <= centre;
      end
   end

   // Operand stage: pair the neighbours before the multipliers
   logic    c_valid_ff;
   tag_type c_tag_ff;
   val_type c_centre_ff, c_south_ff;
   sum_type c_ns_ff, c_we_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         c_tag_ff    <= b_tag_ff;
         c_centre_ff <= centre;
         c_south_ff  <= b_v_ff;
         c_ns_ff     <= SUM_W'(north) + SUM_W'(b_v_ff);
         c_we_ff     <= SUM_W'(west) + SUM_W'(east);
      end
   end

   assign out_valid  = c_valid_ff;
   assign out_tag    = c_tag_ff;
   assign out_centre = c_centre_ff;
   assign out_south  = c_south_ff;
   assign out_ns     = c_ns_ff;
   assign out_we     = c_we_ff;

endmodule

[design/hds_calc.sv]
module hds_calc
   import hds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [COEF_W-1:0] coef_x,
   input  logic [COEF_W-1:0] coef_y,
   input  logic              in_valid,
   input  tag_type           in_tag,
   input  val_type           in_centre,
   input  val_type           in_south,
   input  sum_type           in_ns,
   input  sum_type           in_we,
   output logic              push0,
   output logic              push1,
   output rsp_type           rsp0,
   output rsp_type           rsp1
);

   localparam int AC_W  = VAL_W;                 // centre weight, signed
   localparam int PC_W  = AC_W + VAL_W;
   localparam int PN_W  = COEF_W + 1 + SUM_W;
   localparam int ACC_W = PC_W + 1;
   localparam int Q_W   = ACC_W - FRAC_W;

   localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'((2 ** (VAL_W - 1)) - 1);
   localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(-(2 ** (VAL_W - 1)));
   localparam logic signed [AC_W-1:0]  ONE   = AC_W'(2 ** FRAC_W);

   // Centre weight 1 - 2(cx+cy), refreshed every cycle from the registers
   logic signed [AC_W-1:0] ac_ff;
   logic [COEF_W:0]        coef_sum;

   always_comb begin
      coef_sum = {1'b0, coef_x} + {1'b0, coef_y};
   end

   always_ff @(posedge clock) begin
      ac_ff <= ONE - $signed({1'b0, coef_sum, 1'b0});
   end

   // Product stage
   logic                   d_valid_ff;
   tag_type                d_tag_ff;
   val_type                d_centre_ff, d_south_ff;
   logic signed [PC_W-1:0] d_pc_ff;
   logic signed [PN_W-1:0] d_px_ff, d_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         d_tag_ff    <= in_tag;
         d_centre_ff <= in_centre;
         d_south_ff  <= in_south;
         d_pc_ff     <= ac_ff * in_centre;
         d_px_ff     <= $signed({1'b0, coef_x}) * in_ns;
         d_py_ff     <= $signed({1'b0, coef_y}) * in_we;
      end
   end

   // Sum, round half up, saturate
   logic signed [ACC_W-1:0] acc;
   logic signed [Q_W-1:0]   q;
   val_type                 sat;

   always_comb begin
      acc = ACC_W'(d_pc_ff) + ACC_W'(d_px_ff) + ACC_W'(d_py_ff) + RND;
      q   = Q_W'(acc >>> FRAC_W);
      if (q > Q_MAX) begin
         sat = VAL_W'(Q_MAX);
      end else if (q < Q_MIN) begin
         sat = VAL_W'(Q_MIN);
      end else begin
         sat = VAL_W'(q);
      end

      rsp0.value = d_tag_ff.interior ? sat : d_centre_ff;
      rsp0.row   = d_tag_ff.up_row;
      rsp0.col   = d_tag_ff.col;
      rsp0.last  = 1'b0;

      rsp1.value = d_south_ff;
      rsp1.row   = d_tag_ff.row;
      rsp1.col   = d_tag_ff.col;
      rsp1.last  = d_tag_ff.last;

      push0 = adv && d_valid_ff && d_tag_ff.up;
      push1 = adv && d_valid_ff && d_tag_ff.last_row;
   end

endmodule

[design/hds_outq.sv]
module hds_outq
   import hds_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push0,
   input  logic    push1,
   input  rsp_type rsp0,
   input  rsp_type rsp1,
   output logic    adv,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam logic [OQ_AW:0] ADV_MAX = (OQ_AW + 1)'(OQ_DEPTH - 2);

   rsp_type          entry_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OQ_AW:0]   count_ff, count_in;
   logic [OQ_AW-1:0] wr_ptr_nx;
   logic [1:0]       n_push;
   logic             pop;
   rsp_type          first;

   always_comb begin
      pop       = rsp_valid && rsp_ready;
      first     = push0 ? rsp0 : rsp1;
      n_push    = {1'b0, push0} + {1'b0, push1};
      wr_ptr_nx = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + OQ_AW'(n_push);
      rd_ptr_in = rd_ptr_ff + OQ_AW'(pop);
      count_in  = count_ff + (OQ_AW + 1)'(n_push) - (OQ_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0 || push1) begin
         entry_ff[wr_ptr_ff] <= first;
      end
      if (push0 && push1) begin
         entry_ff[wr_ptr_nx] <= rsp1;
      end
   end

   // Keep room for the two beats a last-row cell can raise
   assign adv       = count_ff <= ADV_MAX;
   assign rsp_valid = count_ff != '0;
   assign rsp       = entry_ff[rd_ptr_ff];

endmodule
